// ===== rtl/pha_pkg.sv =====
// shared types and constants of the proximity haptic alerter
package pha_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ALPHA    = 3'd0;
  localparam logic [2:0] REG_QUALIFY  = 3'd1;
  localparam logic [2:0] REG_REST     = 3'd2;
  localparam logic [2:0] REG_PULSE    = 3'd3;
  localparam logic [2:0] REG_DUTY     = 3'd4;

  // configuration reset values
  localparam logic [15:0] ALPHA_RESET   = 16'd64225;
  localparam logic [7:0]  QUALIFY_RESET = 8'd80;
  localparam logic [7:0]  REST_RESET    = 8'd50;
  localparam logic [15:0] PULSE_RESET   = 16'd80;
  localparam logic [7:0]  DUTY_RESET    = 8'd104;

  // descending distance breakpoints
  localparam logic [15:0] BRK_1 = 16'd5504;
  localparam logic [15:0] BRK_2 = 16'd3130;
  localparam logic [15:0] BRK_3 = 16'd2360;
  localparam logic [15:0] BRK_4 = 16'd1720;
  localparam logic [15:0] BRK_5 = 16'd1442;
  localparam logic [15:0] BRK_LOW = 16'd700;

  localparam logic [9:0] INTERVAL_MAX = 10'd1023;

  // motor phases
  localparam logic [1:0] PH_STOP = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_REST = 2'd2;

  // chosen side codes
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] alpha_q16;
    logic [7:0]  qualify_samples;
    logic [7:0]  rest_step_ms;
    logic [15:0] pulse_on_ms;
    logic [7:0]  drive_duty;
  } pha_cfg_t;

  typedef struct packed {
    logic [9:0]  held_right;
    logic [9:0]  held_left;
    logic [31:0] now_ms;
  } pha_entry_t;

endpackage

// ===== rtl/pha_in_if.sv =====
// poll channel: two distance samples and the millisecond time
interface pha_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_right;
  logic [15:0] raw_left;
  logic [31:0] now_ms;

  modport source (output valid, raw_right, raw_left, now_ms, input ready);
  modport sink (input valid, raw_right, raw_left, now_ms, output ready);
endinterface

// ===== rtl/pha_out_if.sv =====
// result channel: motor drive and held intervals
interface pha_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive_level;
  logic [1:0] motor_phase;
  logic [9:0] interval_right;
  logic [9:0] interval_left;
  logic [1:0] chosen_side;

  modport source (output valid, drive_level, motor_phase, interval_right, interval_left,
                  chosen_side, input ready);
  modport sink (input valid, drive_level, motor_phase, interval_right, interval_left,
                chosen_side, output ready);
endinterface

// ===== rtl/pha_front.sv =====
// front part: sample smoothing, qualifying and band mapping per channel
module pha_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pha_pkg::pha_cfg_t   cfg,
  pha_in_if.sink              poll,
  output logic                push_valid,
  input  logic                push_ready,
  output pha_pkg::pha_entry_t push_data
);
  import pha_pkg::*;

  localparam logic [15:0] SMASK = 16'((33'd1 << SAMPLE_BITS) - 33'd1);

  typedef struct packed {
    logic [7:0] cnt;
    logic [9:0] held;
  } pha_chan_t;

  // s' = raw + a*(old - raw) / 65536, truncated
  function automatic logic [15:0] smooth_step(input logic [15:0] a, input logic [15:0] old,
                                              input logic [15:0] raw);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] acc;
    diff = $signed({1'b0, old}) - $signed({1'b0, raw});
    prod = $signed({1'b0, a}) * diff;
    acc  = $signed({2'b00, raw, 16'h0000}) + prod;
    return acc[31:16];
  endfunction

  function automatic logic [2:0] band_of(input logic [15:0] v);
    logic [2:0] b;
    if (v >= BRK_2) b = 3'd1;
    else if (v >= BRK_3) b = 3'd2;
    else if (v >= BRK_4) b = 3'd3;
    else if (v >= BRK_5) b = 3'd4;
    else b = 3'd5;
    return b;
  endfunction

  function automatic pha_chan_t chan_step(input logic [15:0] s, input pha_chan_t cur,
                                          input logic [7:0] qs, input logic [7:0] step);
    pha_chan_t  nxt;
    logic [7:0] inc;
    logic [10:0] iv;
    inc = cur.cnt + 8'd1;
    iv  = 11'(band_of(s)) * 11'(step);
    if (s >= BRK_LOW) begin
      if (inc >= qs) begin
        nxt.cnt  = 8'd0;
        nxt.held = (iv > 11'(INTERVAL_MAX)) ? INTERVAL_MAX : iv[9:0];
      end else begin
        nxt.cnt  = inc;
        nxt.held = cur.held;
      end
    end else begin
      nxt.cnt  = 8'd0;
      nxt.held = 10'd0;
    end
    return nxt;
  endfunction

  logic        s1_valid;
  logic [31:0] now1;
  logic [15:0] smooth_right;
  logic [15:0] smooth_left;
  logic        s2_valid;
  logic [31:0] now2;
  logic [7:0]  qualify_right;
  logic [7:0]  qualify_left;
  logic [9:0]  held_right;
  logic [9:0]  held_left;

  logic        s1_load;
  logic        s1_move;
  logic        push_fire;
  pha_chan_t   right_next;
  pha_chan_t   left_next;

  assign push_fire  = s2_valid && push_ready;
  assign s1_move    = s1_valid && (!s2_valid || push_fire);
  assign poll.ready = !s1_valid || s1_move;
  assign s1_load    = poll.valid && poll.ready;

  assign right_next = chan_step(smooth_right, '{cnt: qualify_right, held: held_right},
                                cfg.qualify_samples, cfg.rest_step_ms);
  assign left_next  = chan_step(smooth_left, '{cnt: qualify_left, held: held_left},
                                cfg.qualify_samples, cfg.rest_step_ms);

  // stage 1: smoother state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      smooth_right <= 16'd0;
      smooth_left  <= 16'd0;
    end else begin
      s1_valid <= s1_load || (s1_valid && !s1_move);
      if (s1_load) begin
        smooth_right <= smooth_step(cfg.alpha_q16, smooth_right, poll.raw_right & SMASK);
        smooth_left  <= smooth_step(cfg.alpha_q16, smooth_left, poll.raw_left & SMASK);
      end
    end
  end

  // stage 2: qualify counters and held intervals
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid      <= 1'b0;
      qualify_right <= 8'd0;
      qualify_left  <= 8'd0;
      held_right    <= 10'd0;
      held_left     <= 10'd0;
    end else begin
      s2_valid <= s1_move || (s2_valid && !push_fire);
      if (s1_move) begin
        qualify_right <= right_next.cnt;
        held_right    <= right_next.held;
        qualify_left  <= left_next.cnt;
        held_left     <= left_next.held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) now1 <= poll.now_ms;
    if (s1_move) now2 <= now1;
  end

  assign push_valid           = s2_valid;
  assign push_data.held_right = held_right;
  assign push_data.held_left  = held_left;
  assign push_data.now_ms     = now2;

endmodule

// ===== rtl/pha_queue.sv =====
// short queue between the front and back parts
module pha_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  pha_pkg::pha_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output pha_pkg::pha_entry_t pop_data
);
  import pha_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  pha_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("queue count beyond depth");

endmodule

// ===== rtl/pha_back.sv =====
// back part: side choice, motor phase sequencer and result register
module pha_back (
  input  logic                clk,
  input  logic                rst,
  input  pha_pkg::pha_cfg_t   cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  pha_pkg::pha_entry_t pop_data,
  pha_out_if.source           result
);
  import pha_pkg::*;

  logic [1:0]  phase;
  logic [31:0] phase_start;
  logic [1:0]  phase_next;
  logic [31:0] phase_start_next;
  logic [1:0]  side;
  logic [9:0]  iv;
  logic [31:0] elapsed;
  logic        fire;
  logic        out_valid;

  assign fire      = pop_valid && (!out_valid || result.ready);
  assign pop_ready = !out_valid || result.ready;

  // smaller nonzero interval, ties to left
  always_comb begin
    if (pop_data.held_right == 10'd0 && pop_data.held_left == 10'd0) begin
      side = SIDE_NONE;
      iv   = 10'd0;
    end else if (pop_data.held_left == 10'd0) begin
      side = SIDE_RIGHT;
      iv   = pop_data.held_right;
    end else if (pop_data.held_right == 10'd0 || pop_data.held_left <= pop_data.held_right) begin
      side = SIDE_LEFT;
      iv   = pop_data.held_left;
    end else begin
      side = SIDE_RIGHT;
      iv   = pop_data.held_right;
    end
  end

  assign elapsed = pop_data.now_ms - phase_start;

  always_comb begin
    phase_next       = phase;
    phase_start_next = phase_start;
    unique case (phase)
      PH_STOP: begin
        if (iv != 10'd0) begin
          phase_next       = PH_ON;
          phase_start_next = pop_data.now_ms;
        end
      end
      PH_ON: begin
        if (elapsed >= 32'(cfg.pulse_on_ms)) begin
          phase_next       = PH_REST;
          phase_start_next = pop_data.now_ms;
        end
      end
      PH_REST: begin
        if (iv == 10'd0) begin
          phase_next = PH_STOP;
        end else if (elapsed >= 32'(iv)) begin
          phase_next       = PH_ON;
          phase_start_next = pop_data.now_ms;
        end
      end
      default: phase_next = PH_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STOP;
      phase_start <= 32'd0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        phase       <= phase_next;
        phase_start <= phase_start_next;
        out_valid   <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.drive_level    <= (phase_next == PH_ON) ? cfg.drive_duty : 8'd0;
      result.motor_phase    <= phase_next;
      result.interval_right <= pop_data.held_right;
      result.interval_left  <= pop_data.held_left;
      result.chosen_side    <= side;
    end
  end

  assign result.valid = out_valid;

  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.motor_phase != PH_ON |-> result.drive_level == 8'd0)
    else $error("motor driven outside a pulse");

  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.chosen_side == SIDE_NONE) ==
                     (result.interval_right == 10'd0 && result.interval_left == 10'd0))
    else $error("side choice disagrees with held intervals");

  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.motor_phase == PH_ON && !$past(fire) |-> 1'b1 ##0
    result.chosen_side != SIDE_NONE || $past(phase) == PH_ON)
    else $error("pulse started with nothing near");

  assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("motor phase left the valid codes");

endmodule

// ===== rtl/proximity_haptic_alerter_core.sv =====
// top level of the proximity haptic alerter
// The block takes one poll (right and left distance samples plus the millisecond time)
// per clock while the result side is ready and returns one result per poll, in order. A
// poll passes the smoother and qualify stages, the queue and the result register. The
// rate is set by the smoother feedback: each channel folds its new sample into the
// smoothed value with one 17x17 multiply and add before stage 1. The front part smooths,
// counts in-range samples and maps the smoothed distance to a rest interval; a two-entry
// queue then hands the held intervals and the poll time to the back part, which picks the
// side with the shorter interval and steps the motor through stop, pulse and rest. Either
// side may stall without blocking the other until the queue fills. Configuration is taken
// on any cycle through cfg_we, cfg_index and cfg_data and should only change while idle.
module proximity_haptic_alerter_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  pha_in_if.sink      poll,
  pha_out_if.source   result
);
  import pha_pkg::*;

  pha_cfg_t   cfg;
  logic       push_valid;
  logic       push_ready;
  pha_entry_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  pha_entry_t pop_data;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_q16       <= ALPHA_RESET;
      cfg.qualify_samples <= QUALIFY_RESET;
      cfg.rest_step_ms    <= REST_RESET;
      cfg.pulse_on_ms     <= PULSE_RESET;
      cfg.drive_duty      <= DUTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA:   cfg.alpha_q16       <= cfg_data;
        REG_QUALIFY: cfg.qualify_samples <= cfg_data[7:0];
        REG_REST:    cfg.rest_step_ms    <= cfg_data[7:0];
        REG_PULSE:   cfg.pulse_on_ms     <= cfg_data;
        REG_DUTY:    cfg.drive_duty      <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  // smoothing and interval mapping
  pha_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .poll      (poll),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  // decoupling queue
  pha_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  // side choice and motor sequencing
  pha_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .result   (result)
  );

endmodule
